/* hdl/pitch_pulse_scheduler_macros.svh */
// ----------------------------------------------------------------------------
// pitch_pulse_scheduler_macros
// Assertion shorthands for the pitch pulse scheduler.
// ----------------------------------------------------------------------------
`ifndef PITCH_PULSE_SCHEDULER_MACROS_SVH
`define PITCH_PULSE_SCHEDULER_MACROS_SVH

// Same-cycle implication, masked during reset.
`define PPS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pitch_pulse_scheduler: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define PPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pitch_pulse_scheduler: next-cycle check failed");

`endif

/* hdl/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg
// Widths, register indexes and reset values of the pitch pulse scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int INDEX_BITS = 24;   // sample counter width, 16..32
  localparam int OUT_W      = 24;   // position and gap output width
  localparam int F0_W       = 16;
  localparam int SCALE_W    = 24;
  localparam int PHASE_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = F0_W + SCALE_W;
  localparam int STEP_SHIFT = 8;
  localparam int NUM_W      = PHASE_W + 1;   // 2^32 - cur, up to 2^32
  localparam int ALU_W      = NUM_W + 2;     // shifted remainder plus sign
  localparam int QUO_W      = FRAC_W + 1;
  localparam int DIV_STEPS  = QUO_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_F0_FLOOR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_F0_DEFAULT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_PHASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_SHIFT = 3'd4;

  // reset values
  localparam logic [F0_W-1:0]    RST_F0_FLOOR    = 16'd1136;
  localparam logic [F0_W-1:0]    RST_F0_DEFAULT  = 16'd8000;
  localparam logic [SCALE_W-1:0] RST_PHASE_SCALE = 24'd1558282;
  localparam logic [PHASE_W-1:0] RST_START_PHASE = 32'd0;
  localparam logic [FRAC_W-1:0]  RST_START_SHIFT = 16'd0;

endpackage

/* hdl/pitch_pulse_scheduler.sv */
// ----------------------------------------------------------------------------
// pitch_pulse_scheduler
// F0-driven phase accumulator that times vocoder excitation pulses.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | sink      | in_valid / in_ready  | f0_sample, phrase_start
//  out     | source    | out_valid / out_ready| pulse_position, gap_length,
//          |           |                      | voiced, fraction_shift
//  cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Steps: a sample with no phase wrap passes through accept, multiply and add.
//  A wrap then forms the fraction operands, runs 17 steps of the restoring
//  divider and writes the result. The single shared adder/subtractor
//  serialises these steps; the divider produces one quotient bit per cycle.
//  Reset is synchronous; the first sample after reset always starts a phrase.
//  A full output register stalls only the write-back cycle of a pulse.
//  cfg_ready is always high.
//
`include "pitch_pulse_scheduler_macros.svh"

module pitch_pulse_scheduler (
  input  logic                            clk,
  input  logic                            rst,
  // sample input
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pps_pkg::F0_W-1:0]        f0_sample,
  input  logic                            phrase_start,
  // pulse events
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pps_pkg::OUT_W-1:0]       pulse_position,
  output logic [pps_pkg::OUT_W-1:0]       gap_length,
  output logic                            voiced,
  output logic [pps_pkg::FRAC_W-1:0]      fraction_shift,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a sample
  localparam logic [2:0] ST_MUL  = 3'd1;  // step = (f0 * scale) >> 8
  localparam logic [2:0] ST_ADD  = 3'd2;  // phase += step, detect wrap
  localparam logic [2:0] ST_NUM  = 3'd3;  // num = 2^32 - cur
  localparam logic [2:0] ST_DEN  = 3'd4;  // den = num + prev
  localparam logic [2:0] ST_DIV  = 3'd5;  // one quotient bit per cycle
  localparam logic [2:0] ST_EMIT = 3'd6;  // publish previous pulse, store new one

  localparam int IB = pps_pkg::INDEX_BITS;
  localparam int AW = pps_pkg::ALU_W;
  localparam int NW = pps_pkg::NUM_W;
  localparam int PW = pps_pkg::PHASE_W;

  // configuration registers
  logic [pps_pkg::F0_W-1:0]    f0_floor;
  logic [pps_pkg::F0_W-1:0]    f0_default;
  logic [pps_pkg::SCALE_W-1:0] phase_scale;
  logic [PW-1:0]               start_phase;
  logic [pps_pkg::FRAC_W-1:0]  start_shift;

  // control
  logic [2:0]                  state;
  logic                        started;
  logic [pps_pkg::CNT_W-1:0]   cnt;

  // datapath
  logic [pps_pkg::F0_W-1:0]    f0_used;
  logic                        voiced_now;
  logic [PW-1:0]               step;
  logic [PW-1:0]               phase_acc;
  logic [PW-1:0]               prev;
  logic [IB-1:0]               sample_count;
  logic [IB-1:0]               last_pulse;
  logic [pps_pkg::FRAC_W-1:0]  pending_fraction;
  logic                        pending_voiced;
  logic [NW-1:0]               num;
  logic [NW-1:0]               den;
  logic [NW-1:0]               rem;
  logic [pps_pkg::QUO_W-1:0]   quo;

  // shared adder/subtractor
  logic [AW-1:0]               alu_a;
  logic [AW-1:0]               alu_b;
  logic                        alu_sub;
  logic [AW-1:0]               alu_res;

  logic [pps_pkg::PROD_W-1:0]  prod;
  logic                        in_fire;
  logic                        cfg_fire;
  logic                        restart;
  logic                        div_first;
  logic                        div_take;
  logic                        emit_fire;
  logic [pps_pkg::FRAC_W-1:0]  frac_new;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign restart   = phrase_start || !started;

  assign prod      = f0_used * phase_scale;
  assign div_first = (cnt == pps_pkg::CNT_W'(pps_pkg::DIV_STEPS - 1));
  assign div_take  = !alu_res[AW-1];
  assign emit_fire = (state == ST_EMIT) && (!out_valid || out_ready);

  // quotient never exceeds 2^16; the top bit saturates
  assign frac_new = quo[pps_pkg::QUO_W-1] ? {pps_pkg::FRAC_W{1'b1}}
                                          : quo[pps_pkg::FRAC_W-1:0];

  // Operand routing for the one adder. In the divider the remainder is
  // shifted left on every step but the first, since the dividend's top part
  // (num) is already aligned with the divisor.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      ST_ADD: begin
        alu_a = AW'(phase_acc);
        alu_b = AW'(step);
      end
      ST_NUM: begin
        alu_a   = AW'(64'h1_0000_0000);
        alu_b   = AW'(phase_acc);
        alu_sub = 1'b1;
      end
      ST_DEN: begin
        alu_a = AW'(num);
        alu_b = AW'(prev);
      end
      ST_DIV: begin
        alu_a   = div_first ? AW'(rem) : AW'({rem, 1'b0});
        alu_b   = AW'(den);
        alu_sub = 1'b1;
      end
      ST_EMIT: begin
        alu_a   = AW'(sample_count);
        alu_b   = AW'(last_pulse);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_res = alu_a + (alu_b ^ {AW{alu_sub}}) + AW'(alu_sub);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      f0_floor    <= pps_pkg::RST_F0_FLOOR;
      f0_default  <= pps_pkg::RST_F0_DEFAULT;
      phase_scale <= pps_pkg::RST_PHASE_SCALE;
      start_phase <= pps_pkg::RST_START_PHASE;
      start_shift <= pps_pkg::RST_START_SHIFT;
    end else if (cfg_fire) begin
      case (cfg_index)
        pps_pkg::REG_F0_FLOOR:    f0_floor    <= cfg_data[pps_pkg::F0_W-1:0];
        pps_pkg::REG_F0_DEFAULT:  f0_default  <= cfg_data[pps_pkg::F0_W-1:0];
        pps_pkg::REG_PHASE_SCALE: phase_scale <= cfg_data[pps_pkg::SCALE_W-1:0];
        pps_pkg::REG_START_PHASE: start_phase <= cfg_data[PW-1:0];
        pps_pkg::REG_START_SHIFT: start_shift <= cfg_data[pps_pkg::FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and control flops
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      started   <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            started <= 1'b1;
            state   <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_ADD;
        ST_ADD: state <= alu_res[PW] ? ST_NUM : ST_IDLE;
        ST_NUM: state <= ST_DEN;
        ST_DEN: begin
          cnt   <= pps_pkg::CNT_W'(pps_pkg::DIV_STEPS - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          voiced_now <= (f0_sample >= f0_floor);
          f0_used    <= (f0_sample >= f0_floor) ? f0_sample : f0_default;
          if (restart) begin
            phase_acc        <= start_phase;
            pending_fraction <= start_shift;
            sample_count     <= '0;
            last_pulse       <= '0;
            pending_voiced   <= (f0_sample >= f0_floor);
          end
        end
      end
      ST_MUL: step <= prod[pps_pkg::STEP_SHIFT +: PW];
      ST_ADD: begin
        prev      <= phase_acc;
        phase_acc <= alu_res[PW-1:0];
        if (!alu_res[PW]) begin
          sample_count <= sample_count + 1'b1;
        end
      end
      ST_NUM: num <= alu_res[NW-1:0];
      ST_DEN: begin
        den <= alu_res[NW-1:0];
        rem <= num;
        quo <= '0;
      end
      ST_DIV: begin
        rem <= div_take ? alu_res[NW-1:0] : alu_a[NW-1:0];
        quo <= {quo[pps_pkg::QUO_W-2:0], div_take};
      end
      ST_EMIT: begin
        if (emit_fire) begin
          pulse_position   <= pps_pkg::OUT_W'(last_pulse);
          gap_length       <= pps_pkg::OUT_W'(alu_res[IB-1:0]);
          voiced           <= pending_voiced;
          fraction_shift   <= pending_fraction;
          last_pulse       <= sample_count;
          pending_fraction <= frac_new;
          pending_voiced   <= voiced_now;
          sample_count     <= sample_count + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // divider remainder stays below the divisor on every step
  `PPS_ASSERT_NOW(a_rem_below_den, clk, rst, state == ST_DIV, rem < den)
  // a sample transaction always moves on to the multiply cycle
  `PPS_ASSERT_NEXT(a_accept_to_mul, clk, rst, in_fire, state == ST_MUL && !in_ready)
  // a write-back always leaves an event on the output
  `PPS_ASSERT_NEXT(a_emit_valid, clk, rst, emit_fire, out_valid && state == ST_IDLE)

endmodule
